>>> hw/rtl/hdu_pkg.sv
// shared types and constants for the half-duplex 8n1 uart
// no dependencies; used by the interfaces, the bit timer and the top level
package hdu_pkg;

	localparam int unsigned DataBits   = 8;
	localparam int unsigned TickBits   = 8;
	localparam int unsigned IndexBits  = 4;
	localparam logic [IndexBits-1:0] BitEvents = IndexBits'(9);
	localparam logic [TickBits-1:0]  BitTicksReset = TickBits'(13);

	typedef logic [DataBits-1:0] data_t;
	typedef logic [TickBits-1:0] tick_t;

	// control from the sequencer to the bit timer
	typedef struct packed {
		logic  step;      // count one tick
		logic  load;      // load a new delay, overrides step
		tick_t load_val;  // delay to load
	} timer_ctrl_t;

endpackage

>>> hw/rtl/hdu_if.sv
// valid/ready channel interfaces for the half-duplex 8n1 uart
// depends on hdu_pkg
interface hdu_cmd_if;
	logic                valid;
	logic                ready;
	logic                req_type;
	logic                rx_line;
	hdu_pkg::data_t      tx_byte;

	modport source (output valid, req_type, rx_line, tx_byte, input ready);
	modport sink   (input valid, req_type, rx_line, tx_byte, output ready);
endinterface

interface hdu_rsp_if;
	logic                valid;
	logic                ready;
	logic                tx_line;
	logic                rx_valid;
	hdu_pkg::data_t      rx_byte;
	logic                tx_busy;
	logic                rx_busy;

	modport source (output valid, tx_line, rx_valid, rx_byte, tx_busy, rx_busy, input ready);
	modport sink   (input valid, tx_line, rx_valid, rx_byte, tx_busy, rx_busy, output ready);
endinterface

interface hdu_cfg_if;
	logic                valid;
	logic                ready;
	hdu_pkg::tick_t      data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/half_duplex_uart_8n1.sv
// top level of the half-duplex 8n1 uart: sequencer, shift registers, result register
// depends on hdu_pkg, hdu_if and hdu_bit_timer
//
// Each request on cmd is either one baud tick with a sample of the receive line
// (req_type 0) or a send request carrying a byte (req_type 1), and each request
// yields exactly one result on rsp holding the transmit line level, a one-shot
// received-byte flag with its byte, and the busy flags, all taken after the update.
// A request is taken every clock: the state is updated in the cycle it is accepted
// and the result lands in a one-deep output register, so cmd stays ready while a
// result waits as long as rsp takes it in the same cycle. When idle, a falling edge
// starts a receive sampled nine times, first bit_ticks - bit_ticks/2 ticks after the
// edge and then every bit_ticks ticks, LSB first, with no stop-bit check. A send
// request aborts any receive or restarts a transmit and shifts out a start bit and
// eight data bits; the line returns high on the ninth bit event. bit_ticks 0 acts as
// 256 for the bit period. Write bit_ticks on cfg only while no results are pending.
module half_duplex_uart_8n1 (
	input  logic    clk,
	input  logic    arst_n,
	hdu_cfg_if.sink cfg,
	hdu_cmd_if.sink cmd,
	hdu_rsp_if.source rsp
);
	import hdu_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_RX,
		MODE_TX
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [IndexBits-1:0] index_q, index_d, index_inc;
	data_t             rx_shift_q, rx_shift_d, rx_next;
	data_t             tx_shift_q, tx_shift_d;
	logic              line_q, line_d;
	logic              last_rx_q;
	tick_t             bit_ticks_q;
	logic              rsp_valid_q;
	logic              rsp_rx_valid_q;
	data_t             rsp_rx_byte_q;
	logic              accept;
	logic              got_valid;
	data_t             got_byte;
	logic              bit_event;
	timer_ctrl_t       timer_ctrl;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BitTicksReset;
		end else if (cfg.valid) begin
			bit_ticks_q <= cfg.data;
		end
	end

	// take a request when the result register is empty or draining
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	hdu_bit_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (timer_ctrl),
		.bit_ticks (bit_ticks_q),
		.bit_event (bit_event)
	);

	assign index_inc = index_q + IndexBits'(1);
	assign rx_next   = {cmd.rx_line, rx_shift_q[DataBits-1:1]};

	// next state for one request
	always_comb begin
		mode_d              = mode_q;
		index_d             = index_q;
		rx_shift_d          = rx_shift_q;
		tx_shift_d          = tx_shift_q;
		line_d              = line_q;
		got_valid           = 1'b0;
		got_byte            = '0;
		timer_ctrl.step     = 1'b0;
		timer_ctrl.load     = 1'b0;
		timer_ctrl.load_val = bit_ticks_q;
		if (cmd.req_type) begin
			// send request aborts a receive or restarts a transmit
			mode_d          = MODE_TX;
			tx_shift_d      = cmd.tx_byte;
			rx_shift_d      = '0;
			index_d         = '0;
			line_d          = 1'b0;
			timer_ctrl.load = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_RX: begin
					timer_ctrl.step = 1'b1;
					if (bit_event) begin
						rx_shift_d = rx_next;
						index_d    = index_inc;
						if (index_inc >= BitEvents) begin
							got_valid  = 1'b1;
							got_byte   = rx_next;
							rx_shift_d = '0;
							index_d    = '0;
							mode_d     = MODE_IDLE;
						end
					end
				end
				MODE_TX: begin
					timer_ctrl.step = 1'b1;
					if (bit_event) begin
						line_d     = tx_shift_q[0];
						tx_shift_d = tx_shift_q >> 1;
						index_d    = index_inc;
						if (index_inc >= BitEvents) begin
							line_d     = 1'b1;
							tx_shift_d = '0;
							index_d    = '0;
							mode_d     = MODE_IDLE;
						end
					end
				end
				default: begin
					// idle: a falling edge starts a receive at mid bit
					if (last_rx_q && !cmd.rx_line) begin
						mode_d              = MODE_RX;
						index_d             = '0;
						rx_shift_d          = '0;
						timer_ctrl.load     = 1'b1;
						timer_ctrl.load_val = bit_ticks_q - (bit_ticks_q >> 1);
					end
				end
			endcase
		end
		if (!accept) begin
			timer_ctrl.step = 1'b0;
			timer_ctrl.load = 1'b0;
		end
	end

	// sequencer state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			index_q        <= '0;
			rx_shift_q     <= '0;
			tx_shift_q     <= '0;
			line_q         <= 1'b1;
			last_rx_q      <= 1'b1;
			rsp_valid_q    <= 1'b0;
			rsp_rx_valid_q <= 1'b0;
			rsp_rx_byte_q  <= '0;
		end else begin
			if (accept) begin
				mode_q         <= mode_d;
				index_q        <= index_d;
				rx_shift_q     <= rx_shift_d;
				tx_shift_q     <= tx_shift_d;
				line_q         <= line_d;
				rsp_rx_valid_q <= got_valid;
				rsp_rx_byte_q  <= got_byte;
				if (!cmd.req_type) begin
					last_rx_q <= cmd.rx_line;
				end
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// busy flags and line level follow the committed state
	assign rsp.valid    = rsp_valid_q;
	assign rsp.tx_line  = line_q;
	assign rsp.rx_valid = rsp_rx_valid_q;
	assign rsp.rx_byte  = rsp_rx_byte_q;
	assign rsp.tx_busy  = (mode_q == MODE_TX);
	assign rsp.rx_busy  = (mode_q == MODE_RX);

	// a completed byte always ends the receive
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.rx_valid |-> !rsp.rx_busy && !rsp.tx_busy)
		else $error("received byte reported while still busy");

	// a send request drives the start bit in its own result
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.req_type |=> rsp.valid && rsp.tx_busy && !rsp.tx_line)
		else $error("send request did not start a transmit");

	// the transmit line is high whenever no transmit runs
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.tx_busy |-> rsp.tx_line)
		else $error("transmit line low while not transmitting");

	// without an accepted request the committed state stays unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(mode_q) && $stable(index_q) && $stable(line_q))
		else $error("state changed without an accepted request");

endmodule

>>> hw/rtl/hdu_bit_timer.sv
// bit timer: down counter modulo 256 that flags a bit event when the next step would reach zero
// depends on hdu_pkg
module hdu_bit_timer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hdu_pkg::timer_ctrl_t ctrl,
	input  hdu_pkg::tick_t       bit_ticks,
	output logic                 bit_event
);
	import hdu_pkg::*;

	tick_t count_q;
	tick_t count_dec;

	// decrement and zero detect, a bit event when the next step reaches zero
	assign count_dec = count_q - tick_t'(1);
	assign bit_event = (count_dec == '0);

	// counter, reloaded with the bit width on each event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.load) begin
			count_q <= ctrl.load_val;
		end else if (ctrl.step) begin
			count_q <= (count_dec == '0) ? bit_ticks : count_dec;
		end
	end

endmodule

>>> dv/half_duplex_uart_8n1_test.sv
// self-checking testbench for the half-duplex 8n1 uart: predicts every response per request
// depends on hdu_pkg, the hdu_if interfaces and the half_duplex_uart_8n1 top level
module half_duplex_uart_8n1_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hdu_pkg::*;

	localparam int StallLimit = 1000;
	localparam int PhaseItems = 90;
	localparam int HoldCycles = 120;
	localparam int HoldAtResult = 400;

	typedef enum logic [1:0] {
		LINK_IDLE = 2'd0,
		LINK_RX   = 2'd1,
		LINK_TX   = 2'd2
	} link_t;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SEND = 1'b1;

	typedef struct packed {
		logic  tx_line;
		logic  rx_valid;
		data_t rx_byte;
		logic  tx_busy;
		logic  rx_busy;
	} uart_result_t;

	// line state predictor plus the queue of responses still owed by the block
	class uart_scoreboard;
		tick_t          divisor;
		link_t          mode;
		logic [3:0]     bits_done;
		tick_t          countdown;
		data_t          rx_sr;
		data_t          tx_sr;
		logic           tx_level;
		logic           prev_rx;
		uart_result_t   owed_q[$];
		int             errors;
		int             bytes_expected;
		int             sends_seen;

		function new();
			divisor = BitTicksReset;
			mode = LINK_IDLE;
			bits_done = '0;
			countdown = '0;
			rx_sr = '0;
			tx_sr = '0;
			tx_level = 1'b1;
			prev_rx = 1'b1;
			errors = 0;
			bytes_expected = 0;
			sends_seen = 0;
		endfunction

		function void set_divisor(tick_t value);
			divisor = value;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// one tick of the baud timer, true on a bit event (0 wraps to 256)
		function bit bit_event();
			countdown = tick_t'(countdown - 1'b1);
			if (countdown != 0) begin
				return 1'b0;
			end
			countdown = divisor;
			return 1'b1;
		endfunction

		function void note_request(logic req, logic level, data_t byte_in);
			uart_result_t res;
			res = '0;
			if (req == REQ_SEND) begin
				// send aborts a receive or restarts a transmit
				mode = LINK_TX;
				tx_sr = byte_in;
				rx_sr = '0;
				bits_done = '0;
				countdown = divisor;
				tx_level = 1'b0;
				sends_seen++;
			end else begin
				case (mode)
					LINK_RX: begin
						if (bit_event()) begin
							rx_sr = {level, rx_sr[7:1]};
							bits_done = bits_done + 1'b1;
							if (bits_done >= BitEvents) begin
								res.rx_valid = 1'b1;
								res.rx_byte = rx_sr;
								rx_sr = '0;
								bits_done = '0;
								mode = LINK_IDLE;
								bytes_expected++;
							end
						end
					end
					LINK_TX: begin
						if (bit_event()) begin
							tx_level = tx_sr[0];
							tx_sr = tx_sr >> 1;
							bits_done = bits_done + 1'b1;
							// line goes high on the ninth event, stop bit not timed
							if (bits_done >= BitEvents) begin
								tx_level = 1'b1;
								tx_sr = '0;
								bits_done = '0;
								mode = LINK_IDLE;
							end
						end
					end
					default: begin
						// falling edge starts a receive, first sample mid start bit
						if (prev_rx && !level) begin
							mode = LINK_RX;
							bits_done = '0;
							rx_sr = '0;
							countdown = tick_t'(divisor - (divisor >> 1));
						end
					end
				endcase
				prev_rx = level;
			end
			res.tx_line = tx_level;
			res.tx_busy = (mode == LINK_TX);
			res.rx_busy = (mode == LINK_RX);
			owed_q.push_back(res);
		endfunction

		function void check_result(uart_result_t got);
			uart_result_t want;
			if (owed_q.size() == 0) begin
				$error("response with nothing owed: %p", got);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.tx_line !== want.tx_line) begin
				$error("tx_line: expected %0b, got %0b", want.tx_line, got.tx_line);
				errors++;
			end
			if (got.rx_valid !== want.rx_valid) begin
				$error("rx_valid: expected %0b, got %0b", want.rx_valid, got.rx_valid);
				errors++;
			end
			if (got.rx_byte !== want.rx_byte) begin
				$error("rx_byte: expected %02h, got %02h", want.rx_byte, got.rx_byte);
				errors++;
			end
			if (got.tx_busy !== want.tx_busy) begin
				$error("tx_busy: expected %0b, got %0b", want.tx_busy, got.tx_busy);
				errors++;
			end
			if (got.rx_busy !== want.rx_busy) begin
				$error("rx_busy: expected %0b, got %0b", want.rx_busy, got.rx_busy);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hdu_cfg_if cfg_ch ();
	hdu_cmd_if cmd_ch ();
	hdu_rsp_if rsp_ch ();

	half_duplex_uart_8n1 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	uart_scoreboard board = new();
	int  items_sent = 0;
	int  results_taken = 0;
	int  settings_used = 0;
	int  eff_bit = 13;
	bit  send_no_idle = 1'b0;
	bit  recv_no_idle = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// per-item wait, with occasional stretches of back-to-back traffic
	function automatic int draw_gap(inout bit no_idle);
		if ($urandom_range(0, 49) == 0) begin
			no_idle = !no_idle;
		end
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	// one request on cmd, returns at the edge where it was taken
	task automatic drive_request(input logic req, input logic level, input data_t value);
		int gap;
		gap = draw_gap(send_no_idle);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.req_type <= req;
		cmd_ch.rx_line <= level;
		cmd_ch.tx_byte <= value;
		do @(posedge clk); while (!cmd_ch.ready);
		board.note_request(req, level, value);
		items_sent++;
	endtask

	task automatic tick(input logic level);
		drive_request(REQ_TICK, level, data_t'($urandom));
	endtask

	task automatic send_byte(input data_t value);
		drive_request(REQ_SEND, 1'($urandom), value);
	endtask

	task automatic idle_ticks(input int n);
		repeat (n) tick(1'b1);
	endtask

	// start bit, 8 data bits lsb first, stop; a send can be slipped in at abort_at
	task automatic rx_frame(input data_t value, input int blen, input int stop_len,
			input int abort_at);
		int   n;
		int   len;
		logic level;
		n = 0;
		for (int b = 0; b < 10; b++) begin
			level = (b == 0) ? 1'b0 : (b == 9) ? 1'b1 : value[b-1];
			len = (b == 9) ? stop_len : blen;
			repeat (len) begin
				if (n == abort_at) begin
					send_byte(data_t'($urandom));
				end
				tick(level);
				n++;
			end
		end
	endtask

	// stop offering and wait until every owed response has come back
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bit_ticks(input tick_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.set_divisor(value);
		eff_bit = (value == 0) ? 256 : int'(value);
		settings_used++;
	endtask

	function automatic data_t pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return data_t'($urandom);
		endcase
	endfunction

	// one random sequence: mostly clean frames and sends, some noise and broken frames
	task automatic random_sequence();
		int pick;
		int blen;
		int abort_at;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			blen = eff_bit;
			if ($urandom_range(0, 9) == 0) begin
				blen = eff_bit + $urandom_range(0, 2) - 1;
				if (blen < 1) blen = 1;
			end
			abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9 * blen) : -1;
			idle_ticks($urandom_range(1, 3));
			rx_frame(pick_byte(), blen, $urandom_range(1, 2 * eff_bit), abort_at);
		end else if (pick < 80) begin
			send_byte(pick_byte());
			if ($urandom_range(0, 7) == 0) begin
				idle_ticks($urandom_range(1, 5 * eff_bit));
				send_byte(pick_byte());
			end
			repeat (9 * eff_bit + $urandom_range(0, 2)) tick(($urandom_range(0, 5) != 0));
		end else begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_byte(data_t'($urandom));
				end else begin
					tick(1'($urandom));
				end
			end
		end
	endtask

	task automatic random_phase(input tick_t value);
		int stop_at;
		settle();
		write_bit_ticks(value);
		stop_at = items_sent + PhaseItems;
		while (items_sent < stop_at) random_sequence();
	endtask

	// response side: random stalls plus one long hold so the block backs up
	initial begin
		int gap;
		uart_result_t got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_no_idle);
			if (results_taken == HoldAtResult) begin
				gap = HoldCycles;
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.tx_line = rsp_ch.tx_line;
			got.rx_valid = rsp_ch.rx_valid;
			got.rx_byte = rsp_ch.rx_byte;
			got.tx_busy = rsp_ch.tx_busy;
			got.rx_busy = rsp_ch.rx_busy;
			board.check_result(got);
			results_taken++;
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin
		int stall;
		stall = 0;
		while (stall < StallLimit) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("no progress for %0d cycles", StallLimit);
		$display("TEST FAILED");
		$finish;
	end

	// reset, directed cases, random phases, divisor extremes
	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.req_type <= REQ_TICK;
		cmd_ch.rx_line <= 1'b1;
		cmd_ch.tx_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames: all-zero and all-one bytes, tx with a busy rx line
		write_bit_ticks(8'd2);
		idle_ticks(2);
		rx_frame(8'h00, 2, 2, -1);
		idle_ticks(1);
		rx_frame(8'hFF, 2, 2, -1);
		send_byte(8'h00);
		repeat (6) tick(1'b0);
		idle_ticks(14);
		// restart of a running transmit, line toggles ignored while sending
		send_byte(8'hFF);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		send_byte(8'h5A);
		idle_ticks(19);
		// send request aborts a receive halfway
		rx_frame(8'hC3, 2, 2, 7);
		idle_ticks(20);

		random_phase(8'd3);
		random_phase(8'd16);
		random_phase(8'd5);
		random_phase(BitTicksReset);

		// widest divisor: mid start bit sample, then a send aborts the receive
		settle();
		write_bit_ticks(8'd255);
		idle_ticks(2);
		repeat (140) tick(1'b0);
		send_byte(8'hA5);
		idle_ticks(260);
		// zero divisor counts as 256 ticks per bit
		settle();
		write_bit_ticks(8'd0);
		send_byte(8'h3D);
		idle_ticks(300);
		// one tick per bit, picks up the running transmit mid-count
		random_phase(8'd1);

		random_phase(tick_t'($urandom_range(2, 8)));

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d requests (%0d sends) under %0d divisor settings",
			items_sent, board.sends_seen, settings_used);
		$display("checked %0d responses, %0d bytes received, %0d mismatches",
			results_taken, board.bytes_expected, board.errors);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
